>>> hdl/srls_pkg.sv
// Shared types and request codes for the sparse row list store.
package srls_pkg;

    // Request codes carried in the req_type field.
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_FETCH = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    // One request beat.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  row_index;
        logic [15:0] col_index;
        logic [63:0] write_value;
    } t_req;

    // One response beat.
    typedef struct packed {
        logic [63:0] read_value;
        logic        found;
        logic        status;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic cmp_en;
        logic act_en;
        logic out_load;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_ctl_sts;

endpackage

>>> hdl/srls_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module srls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/srls_ctrl.sv
// Controller state machine that sequences one request through the datapath.
module srls_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  srls_pkg::t_ctl_sts    i_sts,
    output srls_pkg::t_ctl_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_ACT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state: lookup, compare, act, then wait for the response register.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP:  n_state = S_ACT;
            S_ACT:  n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Command decode.
    assign o_ready         = (r_state == S_IDLE);
    assign o_cmd.accept    = (r_state == S_IDLE) && i_valid;
    assign o_cmd.cmp_en    = (r_state == S_CMP);
    assign o_cmd.act_en    = (r_state == S_ACT);
    assign o_cmd.out_load  = (r_state == S_DONE) && i_sts.out_free;

endmodule

>>> hdl/srls_dp.sv
// Datapath: row fill, column and value memories, row match and response register.
module srls_dp #(
    parameter int NUM_ROWS     = 256,
    parameter int ROW_CAPACITY = 16,
    parameter int NUM_COLS     = 65536
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  srls_pkg::t_req        i_req,
    input  srls_pkg::t_ctl_cmd    i_cmd,
    output srls_pkg::t_ctl_sts    o_sts,
    output logic                  o_valid,
    input  logic                  i_ready,
    output srls_pkg::t_rsp        o_rsp
);

    // Only 256 rows are reachable through the 8-bit row field.
    localparam int NROWS_EFF = (NUM_ROWS < 256) ? NUM_ROWS : 256;
    localparam int ROW_W     = (NROWS_EFF > 1) ? $clog2(NROWS_EFF) : 1;
    localparam int FILL_W    = $clog2(ROW_CAPACITY + 1);
    localparam int SLOT_W    = (ROW_CAPACITY > 1) ? $clog2(ROW_CAPACITY) : 1;
    localparam int VDEPTH    = NROWS_EFF * ROW_CAPACITY;
    localparam int VADDR_W   = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
    localparam int COLS_W    = 16 * ROW_CAPACITY;

    // Request and compare-stage registers.
    srls_pkg::t_req      r_req;
    logic [FILL_W-1:0]   r_fill;
    logic                r_hit;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_in_range;
    logic                r_found;
    logic                r_status;
    logic                r_rd_sel;
    logic                r_out_valid;
    srls_pkg::t_rsp      r_rsp;
    logic [NROWS_EFF-1:0] r_row_valid;

    // Memory ports.
    logic [FILL_W-1:0]   fill_q;
    logic                fill_we;
    logic [COLS_W-1:0]   cols_q;
    logic [COLS_W-1:0]   cols_wdata;
    logic [63:0]         val_q;
    logic                val_we;
    logic                val_re;
    logic [63:0]         val_wdata;
    logic [VADDR_W-1:0]  val_addr;

    logic [ROW_W-1:0]    in_row;
    logic [ROW_W-1:0]    req_row;
    logic [FILL_W-1:0]   cur_fill;
    logic                cmp_hit;
    logic [SLOT_W-1:0]   cmp_slot;
    logic                cmp_in_range;
    logic                is_write;
    logic                is_fetch;
    logic                is_read;
    logic                is_clear;
    logic                row_full;
    logic                do_append;
    logic [SLOT_W-1:0]   act_slot;

    assign in_row  = i_req.row_index[ROW_W-1:0];
    assign req_row = r_req.row_index[ROW_W-1:0];

    assign is_write = (r_req.req_type == srls_pkg::REQ_WRITE);
    assign is_fetch = (r_req.req_type == srls_pkg::REQ_FETCH);
    assign is_read  = (r_req.req_type == srls_pkg::REQ_READ);
    assign is_clear = (r_req.req_type == srls_pkg::REQ_CLEAR);

    srls_ram #(.WIDTH(FILL_W), .DEPTH(NROWS_EFF)) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (req_row),
        .i_wdata (r_fill + FILL_W'(1)),
        .i_re    (i_cmd.accept),
        .i_raddr (in_row),
        .o_rdata (fill_q)
    );

    srls_ram #(.WIDTH(COLS_W), .DEPTH(NROWS_EFF)) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (req_row),
        .i_wdata (cols_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (in_row),
        .o_rdata (cols_q)
    );

    srls_ram #(.WIDTH(64), .DEPTH(VDEPTH)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_addr),
        .i_wdata (val_wdata),
        .i_re    (val_re),
        .i_raddr (val_addr),
        .o_rdata (val_q)
    );

    // A row that was cleared or never used reads as empty.
    assign cur_fill = r_row_valid[req_row] ? fill_q : '0;

    // Parallel compare over the used slots of the row; columns are unique per row.
    always_comb begin
        cmp_hit  = 1'b0;
        cmp_slot = '0;
        for (int i = 0; i < ROW_CAPACITY; i++) begin
            if ((FILL_W'(i) < cur_fill) && (cols_q[16*i +: 16] == r_req.col_index)) begin
                cmp_hit  = 1'b1;
                cmp_slot = cmp_slot | SLOT_W'(i);
            end
        end
    end

    assign cmp_in_range = (int'(r_req.row_index) < NUM_ROWS)
                       && (int'(r_req.col_index) < NUM_COLS);

    // Act-stage decisions.
    assign row_full  = (r_fill == FILL_W'(ROW_CAPACITY));
    assign do_append = r_in_range && !is_clear && !r_hit && !row_full
                    && (is_write || is_fetch);
    assign act_slot  = r_hit ? r_slot : r_fill[SLOT_W-1:0];
    assign val_addr  = VADDR_W'(req_row) * VADDR_W'(ROW_CAPACITY) + VADDR_W'(act_slot);
    assign val_wdata = is_write ? r_req.write_value : 64'd0;
    assign val_we    = i_cmd.act_en && r_in_range && !is_clear
                    && ((r_hit && is_write) || do_append);
    assign val_re    = i_cmd.act_en && r_in_range && r_hit && (is_fetch || is_read);
    assign fill_we   = i_cmd.act_en && do_append;

    // Row of columns with the appended column placed at the fill position.
    always_comb begin
        cols_wdata = cols_q;
        for (int i = 0; i < ROW_CAPACITY; i++) begin
            if (FILL_W'(i) == r_fill) begin
                cols_wdata[16*i +: 16] = r_req.col_index;
            end
        end
    end

    // Payload registers of the request, compare and act stages and of the response register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req;
        end
        if (i_cmd.cmp_en) begin
            r_fill     <= cur_fill;
            r_hit      <= cmp_hit;
            r_slot     <= cmp_slot;
            r_in_range <= cmp_in_range && !is_clear;
        end
        if (i_cmd.act_en) begin
            r_found  <= r_in_range && r_hit;
            r_status <= r_in_range && !r_hit && row_full && (is_write || is_fetch);
            r_rd_sel <= r_in_range && r_hit && (is_fetch || is_read);
        end
        if (i_cmd.out_load) begin
            r_rsp.read_value <= r_rd_sel ? val_q : 64'd0;
            r_rsp.found      <= r_found;
            r_rsp.status     <= r_status;
        end
    end

    // Row valid bits: cleared by reset and by a clear request, set on append.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (i_cmd.act_en && is_clear) begin
            r_row_valid <= '0;
        end else if (fill_we) begin
            r_row_valid[req_row] <= 1'b1;
        end
    end

    // Response register handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_ready;
    assign o_valid        = r_out_valid;
    assign o_rsp          = r_rsp;

endmodule

>>> hdl/sparse_row_list_store_unit.sv
// Top level of the sparse row list store: controller plus datapath.
// Steps: an accepted request passes the fill/column memory read, the row compare,
// the value memory access and the response load; no new request is accepted
// until its response is loaded into the output register.
// A response waiting in the output register stalls only the final step.
// Reset (synchronous, active low) empties every row at once through per-row valid bits.
module sparse_row_list_store_unit #(
    parameter int NUM_ROWS     = 256,
    parameter int ROW_CAPACITY = 16,
    parameter int NUM_COLS     = 65536
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  srls_pkg::t_req  i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output srls_pkg::t_rsp  o_rsp
);

    srls_pkg::t_ctl_cmd cmd;
    srls_pkg::t_ctl_sts sts;

    // Sequencer.
    srls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Storage and match logic.
    srls_dp #(
        .NUM_ROWS     (NUM_ROWS),
        .ROW_CAPACITY (ROW_CAPACITY),
        .NUM_COLS     (NUM_COLS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

endmodule

>>> verif/srls_rsp_checker.sv
// Response checker for the sparse row list store: models the row lists and compares beats.
module srls_rsp_checker #(
    parameter int NUM_ROWS     = 256,
    parameter int ROW_CAPACITY = 16,
    parameter int NUM_COLS     = 65536
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic            i_req_ready,
    input  srls_pkg::t_req  i_req,
    input  logic            i_rsp_valid,
    input  logic            i_rsp_ready,
    input  srls_pkg::t_rsp  i_rsp,
    output int              o_fail_count,
    output int              o_pending
);

    // Model of the store: entries in use per row and the per-slot column and value.
    int unsigned   row_fill [NUM_ROWS];
    logic [15:0]   slot_col [NUM_ROWS*ROW_CAPACITY];
    logic [63:0]   slot_val [NUM_ROWS*ROW_CAPACITY];

    // Responses owed by the block, oldest first.
    srls_pkg::t_rsp owed_rsps [$];
    int             fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Applies one request to the model rows and returns the response it must produce.
    function automatic srls_pkg::t_rsp serve_request(input srls_pkg::t_req rq);
        srls_pkg::t_rsp rsp;
        int   base;
        int   fill;
        int   hit;
        rsp = '0;
        hit = -1;
        if (rq.req_type == srls_pkg::REQ_CLEAR) begin
            foreach (row_fill[r]) row_fill[r] = 0;
        end else if (int'(rq.row_index) < NUM_ROWS && int'(rq.col_index) < NUM_COLS) begin
            base = int'(rq.row_index) * ROW_CAPACITY;
            fill = row_fill[rq.row_index];
            // Only the slots in use are searched; the first match wins.
            for (int s = 0; s < fill; s++) begin
                if (hit < 0 && slot_col[base + s] == rq.col_index) hit = base + s;
            end
            rsp.found = (hit >= 0);
            case (rq.req_type)
                srls_pkg::REQ_WRITE: begin
                    if (hit >= 0) begin
                        slot_val[hit] = rq.write_value;
                    end else if (fill < ROW_CAPACITY) begin
                        slot_col[base + fill] = rq.col_index;
                        slot_val[base + fill] = rq.write_value;
                        row_fill[rq.row_index] = fill + 1;
                    end else begin
                        rsp.status = 1'b1;
                    end
                end
                srls_pkg::REQ_FETCH: begin
                    if (hit >= 0) begin
                        rsp.read_value = slot_val[hit];
                    end else if (fill < ROW_CAPACITY) begin
                        slot_col[base + fill] = rq.col_index;
                        slot_val[base + fill] = '0;
                        row_fill[rq.row_index] = fill + 1;
                    end else begin
                        rsp.status = 1'b1;
                    end
                end
                default: begin
                    if (hit >= 0) rsp.read_value = slot_val[hit];
                end
            endcase
        end
        return rsp;
    endfunction

    // Both channels are sampled at the rising edge; a response beat is checked
    // before a request beat of the same edge is modeled.
    always @(posedge i_clk) begin : watch
        srls_pkg::t_rsp want;
        if (!i_rst_n) begin
            foreach (row_fill[r]) row_fill[r] = 0;
            owed_rsps.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (owed_rsps.size() == 0) begin
                    $error("response beat with no request outstanding");
                    fails++;
                end else begin
                    want = owed_rsps.pop_front();
                    if (i_rsp.read_value !== want.read_value) begin
                        $error("read_value: expected %h, got %h", want.read_value,
                               i_rsp.read_value);
                        fails++;
                    end
                    if (i_rsp.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, i_rsp.found);
                        fails++;
                    end
                    if (i_rsp.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_rsp.status);
                        fails++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) owed_rsps.push_back(serve_request(i_req));
        end
        o_pending    <= owed_rsps.size();
        o_fail_count <= fails;
    end

endmodule

>>> verif/sparse_row_list_store_unit_test.sv
// Testbench top for the sparse row list store: clock, reset, request stimulus and verdict.
module sparse_row_list_store_unit_test;

    localparam int NUM_ROWS     = 256;
    localparam int ROW_CAPACITY = 16;
    localparam int NUM_COLS     = 65536;
    localparam int RANDOM_ITEMS = 900;

    // Receiver stall patterns.
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} t_rx_mode;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            req_valid;
    logic            req_ready;
    srls_pkg::t_req  req_bus;
    logic            rsp_valid;
    logic            rsp_ready;
    srls_pkg::t_rsp  rsp_bus;
    int              fail_total;
    int              rsps_pending;
    bit              hold_off_req  = 1'b0;
    bit              hold_off_done = 1'b0;

    sparse_row_list_store_unit #(
        .NUM_ROWS    (NUM_ROWS),
        .ROW_CAPACITY(ROW_CAPACITY),
        .NUM_COLS    (NUM_COLS)
    ) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_valid(req_valid),
        .o_ready(req_ready),
        .i_req  (req_bus),
        .o_valid(rsp_valid),
        .i_ready(rsp_ready),
        .o_rsp  (rsp_bus)
    );

    srls_rsp_checker #(
        .NUM_ROWS    (NUM_ROWS),
        .ROW_CAPACITY(ROW_CAPACITY),
        .NUM_COLS    (NUM_COLS)
    ) rsp_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .i_req_ready (req_ready),
        .i_req       (req_bus),
        .i_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .i_rsp       (rsp_bus),
        .o_fail_count(fail_total),
        .o_pending   (rsps_pending)
    );

    // Clock with a period of 8.
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard limit on the run time.
    initial begin
        #3200000;
        $display("CHECK FAILED");
        $finish;
    end

    // Offers one request beat at the falling edge and holds it until accepted.
    task automatic send_req(input srls_pkg::t_req rq);
        @(negedge clk);
        req_valid <= 1'b1;
        req_bus   <= rq;
        do @(posedge clk); while (!req_ready);
    endtask

    // Drops valid for the given number of cycles.
    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    task automatic put(input logic [1:0] kind, input logic [7:0] row,
                       input logic [15:0] col, input logic [63:0] value);
        srls_pkg::t_req rq;
        rq.req_type    = kind;
        rq.row_index   = row;
        rq.col_index   = col;
        rq.write_value = value;
        send_req(rq);
    endtask

    // Random request that mostly hits a few hot rows and a small column pool,
    // so rows fill up, overflow and get updated; clears are rare.
    function automatic srls_pkg::t_req random_req();
        srls_pkg::t_req rq;
        int   pick;
        pick = $urandom_range(0, 999);
        if (pick < 5)        rq.req_type = srls_pkg::REQ_CLEAR;
        else if (pick < 400) rq.req_type = srls_pkg::REQ_WRITE;
        else if (pick < 700) rq.req_type = srls_pkg::REQ_FETCH;
        else                 rq.req_type = srls_pkg::REQ_READ;
        if ($urandom_range(0, 4) == 0) begin
            rq.row_index = 8'($urandom_range(0, 255));
        end else begin
            rq.row_index = 8'($urandom_range(0, 1));
            if ($urandom_range(0, 1)) rq.row_index = ~rq.row_index;
        end
        if ($urandom_range(0, 3) == 0) begin
            rq.col_index = 16'($urandom_range(0, 65535));
        end else begin
            rq.col_index = 16'($urandom_range(0, 23));
            if ($urandom_range(0, 1)) rq.col_index = ~rq.col_index;
        end
        case ($urandom_range(0, 7))
            0:       rq.write_value = '0;
            1:       rq.write_value = '1;
            default: rq.write_value = {$urandom, $urandom};
        endcase
        return rq;
    endfunction

    // Receiver: picks a new random stall pattern whenever the current one runs out, and once
    // holds off for a long stretch when asked.
    initial begin : receiver
        t_rx_mode mode;
        int       left;
        mode = RX_OPEN;
        left = 0;
        rsp_ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req && !hold_off_done) begin
                rsp_ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_off_done = 1'b1;
            end
            if (left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
                left = $urandom_range(16, 96);
            end
            left--;
            case (mode)
                RX_OPEN:   rsp_ready <= 1'b1;
                RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
                default:   rsp_ready <= ~rsp_ready;
            endcase
        end
    end

    // Stimulus: reset, directed requests, then random bursts.
    initial begin : stimulus
        int burst_left;
        int k;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_bus   <= '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Miss, create by fetch, hit by fetch, update, then read back.
        put(srls_pkg::REQ_READ,  8'd0, 16'd0, 64'h0123_4567_89ab_cdef);
        put(srls_pkg::REQ_FETCH, 8'd0, 16'd0, '1);
        put(srls_pkg::REQ_FETCH, 8'd0, 16'd0, '0);
        put(srls_pkg::REQ_WRITE, 8'd0, 16'd0, '1);
        put(srls_pkg::REQ_READ,  8'd0, 16'd0, '0);
        // Top row and top column; this row is then filled to capacity.
        put(srls_pkg::REQ_WRITE, 8'd255, 16'hffff, 64'ha5a5_5a5a_f00f_0ff0);
        for (k = 1; k <= ROW_CAPACITY - 2; k++) begin
            put(srls_pkg::REQ_WRITE, 8'd255, 16'(k * 4681), {$urandom, $urandom});
        end
        put(srls_pkg::REQ_FETCH, 8'd255, 16'd0, '1);
        // Appends into the full row are dropped; an update still works.
        put(srls_pkg::REQ_WRITE, 8'd255, 16'h7777, '1);
        put(srls_pkg::REQ_FETCH, 8'd255, 16'h8888, '1);
        put(srls_pkg::REQ_WRITE, 8'd255, 16'hffff, 64'h5a5a_a5a5_0ff0_f00f);
        // Clear empties everything that was stored.
        put(srls_pkg::REQ_CLEAR, 8'd255, 16'hffff, '1);
        put(srls_pkg::REQ_READ,  8'd0, 16'd0, '0);

        // Random part in bursts with random gaps.
        burst_left = 0;
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == 300) begin
                // Long receiver hold-off while requests keep coming back to back.
                hold_off_req = 1'b1;
                burst_left   = 40;
            end else if (k == 600) begin
                // Let every outstanding response drain before going on.
                idle_sender(1);
                wait (rsps_pending == 0);
                burst_left = 0;
            end
            if (burst_left == 0) begin
                idle_sender($urandom_range(0, 10));
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            send_req(random_req());
        end

        // Drain and give the verdict.
        @(negedge clk);
        req_valid <= 1'b0;
        wait (rsps_pending == 0);
        repeat (40) @(posedge clk);
        if (fail_total == 0 && rsps_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
